// File: hdl/skt_pkg.sv
`default_nettype none
package skt_pkg;

  localparam int unsigned DEF_CAPACITY     = 64;
  localparam int unsigned DEF_KEY_BITS     = 32;
  localparam int unsigned DEF_PAYLOAD_BITS = 32;

  localparam int unsigned KEY_PORT_BITS     = 32;
  localparam int unsigned PAYLOAD_PORT_BITS = 32;
  localparam int unsigned POS_BITS          = 6;
  localparam int unsigned COUNT_BITS        = 7;

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_FIND   = 3'd1,
    REQ_TAKE   = 3'd2,
    REQ_GET    = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_OK       = 3'd2,
    ST_MISS     = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WAIT,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/skt_mem.sv
`default_nettype none
module skt_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/sorted_key_table_engine.sv
`default_nettype none
// Sorted table of up to CAPACITY unique keys with payloads, held in two
// single-port-read synchronous memories. Find and a replacing insert pass
// through SEARCH, WAIT and CMP for each binary-search probe (log2 of the fill
// count plus one probes). An insert that adds an entry or a take then moves
// entries one at a time through the memory port, each in SHIFT_RD then
// SHIFT_WR. Get passes through READ, clear goes straight to DONE. One request
// is worked on at a time; the result is held in an output register until taken.
module sorted_key_table_engine #(
  parameter int unsigned CAPACITY     = skt_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS     = skt_pkg::DEF_KEY_BITS,
  parameter int unsigned PAYLOAD_BITS = skt_pkg::DEF_PAYLOAD_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          req_type,
  input  wire logic [skt_pkg::KEY_PORT_BITS-1:0]     key,
  input  wire logic [skt_pkg::PAYLOAD_PORT_BITS-1:0] payload,
  input  wire logic [skt_pkg::POS_BITS-1:0]          position,
  input  wire logic                                use_last,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [2:0]                          status,
  output logic      [skt_pkg::POS_BITS-1:0]          found_index,
  output logic      [skt_pkg::KEY_PORT_BITS-1:0]     out_key,
  output logic      [skt_pkg::PAYLOAD_PORT_BITS-1:0] out_payload,
  output logic      [skt_pkg::COUNT_BITS-1:0]        entry_count
);

  import skt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic              cmp_mode;
  logic [CW-1:0]     fill;
  logic [2:0]        rq;
  logic [KEY_BITS-1:0]     rk;
  logic [PAYLOAD_BITS-1:0] rp;
  logic [CW-1:0]     first, size, idx, ptr;
  logic              hit;
  logic [AW-1:0]     mid;

  logic [AW-1:0]     raddr, waddr;
  logic              we;
  logic [KEY_BITS-1:0]     kwd, krd;
  logic [PAYLOAD_BITS-1:0] pwd, prd;

  logic [CW-1:0] half;
  logic [KEY_BITS-1:0] rank_in, rank_mem;
  logic          lt, gt;
  logic [CW-1:0] sel_idx;
  logic          sel_ok;

  logic [CW-1:0]     first_next, size_next, idx_next, ptr_next;
  logic              hit_next;

  logic [2:0]        res_st;
  logic [AW-1:0]     res_fi;
  logic [KEY_BITS-1:0]     res_k;
  logic [PAYLOAD_BITS-1:0] res_p;
  logic [CW-1:0]     res_fill;
  logic              do_shift;
  logic [CW-1:0]     shift_ptr;

  logic [KEY_BITS-1:0]     hold_k;
  logic [PAYLOAD_BITS-1:0] hold_p;
  logic              pending;
  logic              posted;
  logic              post;

  function automatic req_t rq_of(input logic [2:0] v);
    req_t r;
    r = req_t'(v);
    return r;
  endfunction

  skt_mem #(.DEPTH(CAPACITY), .WIDTH(KEY_BITS)) u_kmem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(kwd), .raddr(raddr), .rdata(krd));
  skt_mem #(.DEPTH(CAPACITY), .WIDTH(PAYLOAD_BITS)) u_pmem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(pwd), .raddr(raddr), .rdata(prd));

  always_comb begin
    half = (size - CW'(1)) >> 1;
    rank_in  = rk;
    rank_mem = krd;
    if (cmp_mode) begin
      rank_in[KEY_BITS-1]  = ~rk[KEY_BITS-1];
      rank_mem[KEY_BITS-1] = ~krd[KEY_BITS-1];
    end
    lt = rank_in < rank_mem;
    gt = rank_in > rank_mem;
    if (use_last) begin
      sel_ok  = fill != '0;
      sel_idx = fill - CW'(1);
    end else begin
      sel_ok  = 32'(position) < 32'(fill);
      sel_idx = CW'(position);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_mode <= 1'b0;
    end else if (cfg_we) begin
      cmp_mode <= cfg_wdata;
    end
  end

  // Result and follow-up decision, taken in DONE when the result is posted.
  always_comb begin
    res_st    = ST_MISS;
    res_fi    = '0;
    res_k     = '0;
    res_p     = '0;
    res_fill  = fill;
    do_shift  = 1'b0;
    shift_ptr = fill;
    case (rq)
      REQ_INSERT: begin
        if (hit) begin
          res_st = ST_REPLACED;
          res_fi = AW'(idx);
          res_p  = hold_p;
        end else if (fill >= CW'(CAPACITY)) begin
          res_st = ST_FULL;
        end else begin
          res_st    = ST_INSERTED;
          res_fi    = AW'(idx);
          res_fill  = fill + CW'(1);
          do_shift  = 1'b1;
          shift_ptr = fill;
        end
      end
      REQ_FIND: begin
        if (hit) begin
          res_st = ST_OK;
          res_fi = AW'(idx);
        end
      end
      REQ_TAKE, REQ_GET: begin
        if (pending) begin
          res_st = ST_OK;
          res_fi = AW'(idx);
          res_k  = hold_k;
          res_p  = hold_p;
          if (rq == REQ_TAKE) begin
            res_fill  = fill - CW'(1);
            do_shift  = 1'b1;
            shift_ptr = idx;
          end
        end
      end
      REQ_CLEAR: begin
        res_st   = ST_OK;
        res_fill = '0;
      end
      default: ;
    endcase
  end

  assign post = (state == S_DONE) && !posted && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    first_next = first;
    size_next  = size;
    idx_next   = idx;
    ptr_next   = ptr;
    hit_next   = hit;
    mid        = AW'(first + half);
    raddr      = mid;
    waddr      = AW'(ptr);
    we         = 1'b0;
    kwd        = krd;
    pwd        = prd;
    in_stall   = state != S_IDLE;
    case (state)
      S_IDLE: begin
        raddr = AW'(sel_idx);
        if (in_valid) begin
          first_next = '0;
          size_next  = fill;
          hit_next   = 1'b0;
          idx_next   = sel_idx;
          case (rq_of(req_type))
            REQ_INSERT, REQ_FIND: state_next = S_SEARCH;
            REQ_TAKE, REQ_GET: state_next = sel_ok ? S_READ : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (size == '0) begin
          idx_next   = first;
          state_next = S_DONE;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        mid = AW'(first + half);
        if (lt) begin
          size_next  = half;
          state_next = S_SEARCH;
        end else if (gt) begin
          first_next = first + half + CW'(1);
          size_next  = size - half - CW'(1);
          state_next = S_SEARCH;
        end else begin
          hit_next   = 1'b1;
          idx_next   = CW'(mid);
          state_next = S_DONE;
          if (rq == REQ_INSERT) begin
            we    = 1'b1;
            waddr = mid;
            kwd   = krd;
            pwd   = rp;
          end
        end
      end
      S_READ: begin
        ptr_next   = idx;
        state_next = S_DONE;
      end
      S_SHIFT_RD: begin
        raddr = AW'(ptr);
        if (rq == REQ_INSERT) begin
          if (ptr == idx) begin
            we    = 1'b1;
            waddr = AW'(idx);
            kwd   = rk;
            pwd   = rp;
            state_next = S_DONE;
          end else begin
            raddr = AW'(ptr - CW'(1));
            state_next = S_SHIFT_WR;
          end
        end else begin
          if (ptr >= fill) begin
            state_next = S_DONE;
          end else begin
            raddr = AW'(ptr + CW'(1));
            state_next = S_SHIFT_WR;
          end
        end
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = AW'(ptr);
        if (rq == REQ_INSERT) ptr_next = ptr - CW'(1);
        else ptr_next = ptr + CW'(1);
        state_next = S_SHIFT_RD;
      end
      S_DONE: begin
        if (posted) begin
          state_next = S_IDLE;
        end else if (!out_valid || !out_stall) begin
          if (do_shift) begin
            ptr_next   = shift_ptr;
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
      posted    <= 1'b0;
      pending   <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
      size  <= size_next;
      idx   <= idx_next;
      ptr   <= ptr_next;
      hit   <= hit_next;
      if (state == S_IDLE && in_valid) begin
        rq      <= req_type;
        rk      <= KEY_BITS'(key);
        rp      <= PAYLOAD_BITS'(payload);
        posted  <= 1'b0;
        pending <= 1'b0;
      end
      if (state == S_CMP && !(lt || gt)) hold_p <= prd;
      if (state == S_READ) begin
        hold_k  <= krd;
        hold_p  <= prd;
        pending <= 1'b1;
      end
      if (post) begin
        out_valid   <= 1'b1;
        posted      <= 1'b1;
        status      <= res_st;
        found_index <= POS_BITS'(res_fi);
        out_key     <= KEY_PORT_BITS'(res_k);
        out_payload <= PAYLOAD_PORT_BITS'(res_p);
        entry_count <= COUNT_BITS'(res_fill);
        fill        <= res_fill;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
